>>> rtl/core/q2e_pkg.sv
`default_nettype none

package q2e_pkg;

   // default rotation count of the angle pipeline
   localparam int CORDIC_STAGES_DEF = 16;

   // one root bit per square root stage
   localparam int SQ_STAGES = 29;

   localparam int PW = 32;   // product width
   localparam int SW = 36;   // product sum width
   localparam int XW = 38;   // rotation vector width
   localparam int ZW = 34;   // angle accumulator width, 2^-30 rad

   localparam logic signed [SW-1:0] ONE_Q28 = SW'(64'sd268435456);
   localparam logic signed [ZW-1:0] HPI_Q30 = ZW'(64'sd1686629713);
   localparam logic signed [15:0]   PI_Q13  = 16'sd25736;
   localparam logic signed [15:0]   HPI_Q13 = 16'sd12868;
   localparam logic [56:0]          ONE_Q56 = 57'(1) << 56;

   localparam logic signed [ZW-1:0] ATAN_TAB [0:9] = '{
      ZW'(64'sd843314857), ZW'(64'sd497837829), ZW'(64'sd263043837),
      ZW'(64'sd133525159), ZW'(64'sd67021687),  ZW'(64'sd33543516),
      ZW'(64'sd16775851),  ZW'(64'sd8388437),   ZW'(64'sd4194283),
      ZW'(64'sd2097149)
   };

   typedef struct packed {
      logic signed [XW-1:0] x;
      logic signed [XW-1:0] y;
      logic signed [ZW-1:0] z;
      logic                 zero;
   } vec_type;

   typedef struct packed {
      logic                 valid;
      logic [56:0]          rem;
      logic [57:0]          root;
      logic signed [28:0]   pit_y;
      logic                 sat;
      logic                 sat_pos;
      vec_type              roll;
      vec_type              yaw;
   } sq_type;

   typedef struct packed {
      logic                 valid;
      logic                 sat;
      logic                 sat_pos;
      vec_type              roll;
      vec_type              yaw;
      vec_type              pitch;
   } cd_type;

   // elementary rotation angle of step i
   function automatic logic signed [ZW-1:0] atan_step(input int i);
      logic signed [ZW-1:0] r;
      if (i < 10)
         r = ATAN_TAB[i];
      else if (i <= 30)
         r = ZW'(64'sd1) <<< (30 - i);
      else
         r = '0;
      return r;
   endfunction

   // quarter turn for a negative cosine term
   function automatic vec_type pre_rot(input logic signed [SW-1:0] y,
                                       input logic signed [SW-1:0] x);
      vec_type v;
      v.zero = (x == '0) && (y == '0);
      v.x = XW'(x);
      v.y = XW'(y);
      v.z = '0;
      if (x < 0) begin
         if (y >= 0) begin
            v.z = HPI_Q30;
            v.x = XW'(y);
            v.y = -XW'(x);
         end else begin
            v.z = -HPI_Q30;
            v.x = -XW'(y);
            v.y = XW'(x);
         end
      end
      return v;
   endfunction

   // one vectoring rotation
   function automatic vec_type cordic_iter(input vec_type v, input int i);
      vec_type o;
      logic signed [XW-1:0] xs;
      logic signed [XW-1:0] ys;
      xs = v.x >>> i;
      ys = v.y >>> i;
      o = v;
      if (v.y > 0) begin
         o.x = v.x + ys;
         o.y = v.y - xs;
         o.z = v.z + atan_step(i);
      end else begin
         o.x = v.x - ys;
         o.y = v.y + xs;
         o.z = v.z - atan_step(i);
      end
      return o;
   endfunction

   // round half up to 2^-13 rad and clamp
   function automatic logic signed [15:0] to_q13(input logic signed [ZW-1:0] a,
                                                 input logic signed [15:0] lim);
      logic signed [ZW:0]    t;
      logic signed [ZW-17:0] r;
      logic signed [15:0]    o;
      t = (ZW+1)'(a) + (ZW+1)'(65536);
      r = (ZW-16)'(t >>> 17);
      if (r > (ZW-16)'(lim))
         o = lim;
      else if (r < -(ZW-16)'(lim))
         o = -lim;
      else
         o = 16'(r);
      return o;
   endfunction

endpackage

`default_nettype wire

>>> rtl/core/quaternion_to_euler.sv
`default_nettype none

// Quaternion to roll, pitch and yaw. Takes one Q1.14 quaternion per transfer
// and returns Q2.13 radian roll and yaw and Q1.13 pitch, one result per input,
// in order. The datapath is a single pipeline that accepts an item every cycle
// while no result is stalled; its depth is set by the 29 stage pitch square
// root (one root bit per stage) and the CORDIC rotations (one per stage) that
// roll, yaw and pitch run side by side. A stalled result holds every stage.
// Pitch saturates to plus or minus pi/2 with a flag once its sine reaches one.
module quaternion_to_euler
   import q2e_pkg::*;
#(
   parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   output logic                req_ready,
   input  wire  signed [15:0]  req_quat_w,
   input  wire  signed [15:0]  req_quat_x,
   input  wire  signed [15:0]  req_quat_y,
   input  wire  signed [15:0]  req_quat_z,
   output logic                rsp_valid,
   input  wire                 rsp_ready,
   output logic signed [15:0]  rsp_roll_angle,
   output logic signed [14:0]  rsp_pitch_angle,
   output logic signed [15:0]  rsp_yaw_angle,
   output logic                rsp_pitch_saturated
);

   logic adv;

   // input stage
   logic                a1_valid_ff;
   logic signed [15:0]  w_ff, x_ff, y_ff, z_ff;

   // product stage
   logic                a2_valid_ff;
   logic signed [PW-1:0] wx_ff, yz_ff, xx_ff, yy_ff, zz_ff, wy_ff, zx_ff, wz_ff, xy_ff;

   // sum stage
   logic                a3_valid_ff;
   logic signed [SW-1:0] sr_ff, cr_ff, sy_ff, cy_ff;
   logic signed [28:0]  sp_ff;
   logic                sat_ff, sat_pos_ff;
   logic signed [SW-1:0] sp_in;

   // square and pre-rotation stage
   logic                a4_valid_ff;
   logic [56:0]         s2_ff;
   logic signed [28:0]  sp4_ff;
   logic                sat4_ff, sat_pos4_ff;
   vec_type             roll4_ff, yaw4_ff;

   sq_type sq_ff [0:SQ_STAGES];
   sq_type sq_in [0:SQ_STAGES];
   cd_type cd_ff [0:CORDIC_STAGES];
   cd_type cd_in [0:CORDIC_STAGES];

   logic signed [15:0]  roll_in, yaw_in, pitch_in;

   // whole pipeline moves unless a result waits
   assign adv       = !rsp_valid || rsp_ready;
   assign req_ready = adv;

   assign sp_in = SW'(2) * (SW'(wy_ff) - SW'(zx_ff));

   // square root stages, one root bit each
   always_comb begin
      logic [58:0] trial;
      logic [57:0] bitv;
      sq_in[0].valid   = a4_valid_ff;
      sq_in[0].rem     = ONE_Q56 - s2_ff;
      sq_in[0].root    = '0;
      sq_in[0].pit_y   = sp4_ff;
      sq_in[0].sat     = sat4_ff;
      sq_in[0].sat_pos = sat_pos4_ff;
      sq_in[0].roll    = roll4_ff;
      sq_in[0].yaw     = yaw4_ff;
      for (int j = 0; j < SQ_STAGES; j++) begin
         bitv  = 58'(1) << (2 * (SQ_STAGES - 1 - j));
         trial = 59'(sq_ff[j].root) + 59'(bitv);
         sq_in[j+1] = sq_ff[j];
         if (59'(sq_ff[j].rem) >= trial) begin
            sq_in[j+1].rem  = 57'(59'(sq_ff[j].rem) - trial);
            sq_in[j+1].root = (sq_ff[j].root >> 1) + bitv;
         end else begin
            sq_in[j+1].root = sq_ff[j].root >> 1;
         end
      end
   end

   // rotation stages for all three angles
   always_comb begin
      cd_in[0].valid       = sq_ff[SQ_STAGES].valid;
      cd_in[0].sat         = sq_ff[SQ_STAGES].sat;
      cd_in[0].sat_pos     = sq_ff[SQ_STAGES].sat_pos;
      cd_in[0].roll        = sq_ff[SQ_STAGES].roll;
      cd_in[0].yaw         = sq_ff[SQ_STAGES].yaw;
      cd_in[0].pitch.x     = XW'(sq_ff[SQ_STAGES].root[28:0]);
      cd_in[0].pitch.y     = XW'(sq_ff[SQ_STAGES].pit_y);
      cd_in[0].pitch.z     = '0;
      cd_in[0].pitch.zero  = 1'b0;
      for (int i = 0; i < CORDIC_STAGES; i++) begin
         cd_in[i+1]       = cd_ff[i];
         cd_in[i+1].roll  = cordic_iter(cd_ff[i].roll, i);
         cd_in[i+1].yaw   = cordic_iter(cd_ff[i].yaw, i);
         cd_in[i+1].pitch = cordic_iter(cd_ff[i].pitch, i);
      end
   end

   // rounding and special cases
   always_comb begin
      roll_in = cd_ff[CORDIC_STAGES].roll.zero ? '0
              : to_q13(cd_ff[CORDIC_STAGES].roll.z, PI_Q13);
      yaw_in  = cd_ff[CORDIC_STAGES].yaw.zero ? '0
              : to_q13(cd_ff[CORDIC_STAGES].yaw.z, PI_Q13);
      if (cd_ff[CORDIC_STAGES].sat)
         pitch_in = cd_ff[CORDIC_STAGES].sat_pos ? HPI_Q13 : -HPI_Q13;
      else
         pitch_in = to_q13(cd_ff[CORDIC_STAGES].pitch.z, HPI_Q13);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a1_valid_ff <= 1'b0;
         a2_valid_ff <= 1'b0;
         a3_valid_ff <= 1'b0;
         a4_valid_ff <= 1'b0;
         for (int j = 0; j <= SQ_STAGES; j++)
            sq_ff[j].valid <= 1'b0;
         for (int i = 0; i <= CORDIC_STAGES; i++)
            cd_ff[i].valid <= 1'b0;
         rsp_valid <= 1'b0;
      end else if (adv) begin
         // input transfer
         a1_valid_ff <= req_valid;
         w_ff <= req_quat_w;
         x_ff <= req_quat_x;
         y_ff <= req_quat_y;
         z_ff <= req_quat_z;

         // products
         a2_valid_ff <= a1_valid_ff;
         wx_ff <= PW'(w_ff * x_ff);
         yz_ff <= PW'(y_ff * z_ff);
         xx_ff <= PW'(x_ff * x_ff);
         yy_ff <= PW'(y_ff * y_ff);
         zz_ff <= PW'(z_ff * z_ff);
         wy_ff <= PW'(w_ff * y_ff);
         zx_ff <= PW'(z_ff * x_ff);
         wz_ff <= PW'(w_ff * z_ff);
         xy_ff <= PW'(x_ff * y_ff);

         // product sums and pitch range check
         a3_valid_ff <= a2_valid_ff;
         sr_ff <= SW'(2) * (SW'(wx_ff) + SW'(yz_ff));
         cr_ff <= ONE_Q28 - SW'(2) * (SW'(xx_ff) + SW'(yy_ff));
         sy_ff <= SW'(2) * (SW'(wz_ff) + SW'(xy_ff));
         cy_ff <= ONE_Q28 - SW'(2) * (SW'(yy_ff) + SW'(zz_ff));
         sp_ff <= 29'(sp_in);
         sat_ff <= (sp_in >= ONE_Q28) || (sp_in <= -ONE_Q28);
         sat_pos_ff <= (sp_in >= ONE_Q28);

         // pitch sine squared, roll and yaw pre-rotation
         a4_valid_ff <= a3_valid_ff;
         s2_ff <= 57'(sp_ff * sp_ff);
         sp4_ff <= sp_ff;
         sat4_ff <= sat_ff;
         sat_pos4_ff <= sat_pos_ff;
         roll4_ff <= pre_rot(sr_ff, cr_ff);
         yaw4_ff <= pre_rot(sy_ff, cy_ff);

         for (int j = 0; j <= SQ_STAGES; j++)
            sq_ff[j] <= sq_in[j];
         for (int i = 0; i <= CORDIC_STAGES; i++)
            cd_ff[i] <= cd_in[i];

         // result register
         rsp_valid           <= cd_ff[CORDIC_STAGES].valid;
         rsp_roll_angle      <= roll_in;
         rsp_yaw_angle       <= yaw_in;
         rsp_pitch_angle     <= 15'(pitch_in);
         rsp_pitch_saturated <= cd_ff[CORDIC_STAGES].sat;
      end
   end

endmodule

`default_nettype wire
